/* rtl/crh_pkg.sv */
// shared types and constants for the channel rate histogram
package crh_pkg;

  localparam int unsigned DATA_W = 32;
  localparam logic [DATA_W-1:0] COUNT_MAX = '1;

  localparam logic CMD_EVENT = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  localparam logic STATUS_REPORT = 1'b0;
  localparam logic STATUS_REJECT = 1'b1;

  typedef struct packed {
    logic              command;
    logic [DATA_W-1:0] channel_code;
    logic [DATA_W-1:0] time_seconds;
  } in_item_t;

  typedef struct packed {
    logic              status;
    logic [DATA_W-1:0] channel;
    logic [DATA_W-1:0] count;
    logic [DATA_W-1:0] timestamp;
    logic              first_report;
    logic              last;
  } out_item_t;

  // contents of one channel cell
  typedef struct packed {
    logic [DATA_W-1:0] count;
    logic              seen;
  } cell_data_t;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SWEEP = 3'b010,
    ST_FLUSH = 3'b100
  } state_t;

endpackage

/* rtl/crh_if.sv */
// valid/ready channel interfaces for input and result items
interface crh_in_if import crh_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface crh_out_if import crh_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

/* rtl/crh_cell.sv */
// one channel cell: saturating counter and seen flag, shifts towards the head
module crh_cell import crh_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       shift_en,
  input  cell_data_t shift_in,
  input  logic       inc,
  output cell_data_t data_r
);

  cell_data_t data_nxt;

  always_comb begin
    data_nxt = data_r;
    if (shift_en) begin
      data_nxt = shift_in;
    end else if (inc && (data_r.count != COUNT_MAX)) begin
      data_nxt.count = data_r.count + DATA_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_r <= '0;
    end else begin
      data_r <= data_nxt;
    end
  end

endmodule

/* rtl/channel_rate_histogram_core.sv */
// top level of the per-channel event rate histogram
//
//   port      dir   transfer carries
//   in_chan   in    command, channel_code, time_seconds
//   out_chan  out   status, channel, count, timestamp, first_report, last
//
// an item is taken only while idle and the output register is free; an event
// finishes with its transfer; a tick starts a sweep that rotates the whole cell
// chain past the head, then a flush state; a report that finds the output
// register full holds the sweep
// synchronous reset clears every cell at once, so no clearing pass is needed
// a stalled output holds the chain in place once a report has nowhere to go, nothing is dropped
module channel_rate_histogram_core
  import crh_pkg::*;
#(
  parameter int unsigned CHANNELS = 64
) (
  input logic       clk,
  input logic       rst_n,
  crh_in_if.sink    in_chan,
  crh_out_if.source out_chan
);

  localparam int unsigned CW = $clog2(CHANNELS);

  // cell chain, position 0 is the head that the sweep reads
  cell_data_t        cell_q   [CHANNELS];
  cell_data_t        shift_in [CHANNELS];
  logic [CHANNELS-1:0] inc;

  state_t            state_r, state_nxt;
  logic [CW-1:0]     step_r, step_nxt;
  logic [DATA_W-1:0] ts_r, ts_nxt;

  // output register and the one report held back to learn whether it is last
  out_item_t out_r, out_nxt;
  logic      out_v_r, out_v_nxt;
  out_item_t pend_r, pend_nxt;
  logic      pend_v_r, pend_v_nxt;

  logic       out_free;
  logic       in_acc;
  logic       ev_in_range;
  logic       head_nz;
  logic       advance;
  cell_data_t tail_in;

  assign out_free = !out_v_r || out_chan.ready;

  assign in_chan.ready = (state_r == ST_IDLE) && out_free;
  assign in_acc        = in_chan.valid && in_chan.ready;

  assign ev_in_range = in_chan.payload.channel_code < DATA_W'(CHANNELS);

  assign head_nz = cell_q[0].count != '0;

  // the sweep may move on unless a report has nowhere to go
  assign advance = (state_r == ST_SWEEP) && (!head_nz || !pend_v_r || out_free);

  // head wraps round to the tail cleared, marked seen once it has been reported
  always_comb begin
    tail_in.count = '0;
    tail_in.seen  = cell_q[0].seen | head_nz;
  end

  genvar gi;
  generate
    for (gi = 0; gi < CHANNELS; gi++) begin : g_cell
      if (gi == CHANNELS - 1) begin : g_tail
        assign shift_in[gi] = tail_in;
      end else begin : g_body
        assign shift_in[gi] = cell_q[gi + 1];
      end

      // events land only while idle, when cell positions match channel numbers
      assign inc[gi] = in_acc && (in_chan.payload.command == CMD_EVENT) && ev_in_range &&
                       (in_chan.payload.channel_code[CW-1:0] == CW'(gi));

      crh_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (advance),
        .shift_in (shift_in[gi]),
        .inc      (inc[gi]),
        .data_r   (cell_q[gi])
      );
    end
  endgenerate

  always_comb begin
    state_nxt  = state_r;
    step_nxt   = step_r;
    ts_nxt     = ts_r;
    out_nxt    = out_r;
    out_v_nxt  = out_v_r && !out_chan.ready;
    pend_nxt   = pend_r;
    pend_v_nxt = pend_v_r;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_chan.payload.command == CMD_TICK) begin
            state_nxt = ST_SWEEP;
            step_nxt  = '0;
            ts_nxt    = in_chan.payload.time_seconds;
          end else if (!ev_in_range) begin
            // rejected code goes straight to the output register
            out_nxt.status       = STATUS_REJECT;
            out_nxt.channel      = in_chan.payload.channel_code;
            out_nxt.count        = '0;
            out_nxt.timestamp    = '0;
            out_nxt.first_report = 1'b0;
            out_nxt.last         = 1'b1;
            out_v_nxt            = 1'b1;
          end
        end
      end
      ST_SWEEP: begin
        if (advance) begin
          if (head_nz) begin
            // a newer report means the held one was not the last
            if (pend_v_r) begin
              out_nxt      = pend_r;
              out_nxt.last = 1'b0;
              out_v_nxt    = 1'b1;
            end
            pend_nxt.status       = STATUS_REPORT;
            pend_nxt.channel      = DATA_W'(step_r);
            pend_nxt.count        = cell_q[0].count;
            pend_nxt.timestamp    = ts_r;
            pend_nxt.first_report = !cell_q[0].seen;
            pend_nxt.last         = 1'b0;
            pend_v_nxt            = 1'b1;
          end
          if (step_r == CW'(CHANNELS - 1)) begin
            state_nxt = ST_FLUSH;
            step_nxt  = '0;
          end else begin
            step_nxt = step_r + CW'(1);
          end
        end
      end
      ST_FLUSH: begin
        if (!pend_v_r) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          out_nxt      = pend_r;
          out_nxt.last = 1'b1;
          out_v_nxt    = 1'b1;
          pend_v_nxt   = 1'b0;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      step_r   <= '0;
      out_v_r  <= 1'b0;
      pend_v_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      step_r   <= step_nxt;
      out_v_r  <= out_v_nxt;
      pend_v_r <= pend_v_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    ts_r   <= ts_nxt;
    out_r  <= out_nxt;
    pend_r <= pend_nxt;
  end

  assign out_chan.valid   = out_v_r;
  assign out_chan.payload = out_r;

endmodule

/* verif/channel_rate_histogram_core_tb.sv */
// testbench for the channel rate histogram: random and directed traffic against a predictor
`timescale 1ns / 100ps

module channel_rate_histogram_core_tb;
  import crh_pkg::*;

  localparam int unsigned CHANNELS    = 64;
  localparam int unsigned STALL_LIMIT = 2000;  // cycles without any transfer
  localparam int unsigned WIDE_CODE   = 1024;  // a code far beyond the channel range

  logic clk = 1'b0;
  logic rst_n;

  crh_in_if  in_chan ();
  crh_out_if out_chan ();

  channel_rate_histogram_core #(
    .CHANNELS(CHANNELS)
  ) uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // shadow of the block's tables
  logic [DATA_W-1:0] chan_count [CHANNELS];
  logic              chan_seen  [CHANNELS];

  out_item_t   expected_reports[$];
  int unsigned mismatches  = 0;
  int unsigned idle_cycles = 0;

  // when set, the side concerned runs without gaps
  bit tx_quiet = 1'b0;
  bit rx_quiet = 1'b0;

  // work out the results of one accepted item and update the shadow tables
  function automatic void histogram_predict(input in_item_t item);
    out_item_t rpt;
    int        top;
    top = -1;
    if (item.command == CMD_EVENT) begin
      if (item.channel_code < CHANNELS) begin
        // counter sticks at full scale
        if (chan_count[item.channel_code] != COUNT_MAX)
          chan_count[item.channel_code] = chan_count[item.channel_code] + 1'b1;
      end else begin
        rpt = '{status: STATUS_REJECT, channel: item.channel_code, count: '0,
                timestamp: '0, first_report: 1'b0, last: 1'b1};
        expected_reports.push_back(rpt);
      end
    end else begin
      // highest busy channel carries the last flag
      for (int i = 0; i < CHANNELS; i++)
        if (chan_count[i] != '0) top = i;
      for (int i = 0; i < CHANNELS; i++) begin
        if (chan_count[i] != '0) begin
          rpt = '{status: STATUS_REPORT, channel: DATA_W'(i), count: chan_count[i],
                  timestamp: item.time_seconds, first_report: !chan_seen[i],
                  last: (i == top)};
          expected_reports.push_back(rpt);
          chan_seen[i]  = 1'b1;
          chan_count[i] = '0;
        end
      end
    end
  endfunction

  // one input transfer, preceded by a random gap; prediction follows acceptance
  task automatic send_item(input logic cmd, input logic [DATA_W-1:0] code,
                           input logic [DATA_W-1:0] secs);
    int unsigned gap;
    in_item_t    item;
    gap  = tx_quiet ? 0 : $urandom_range(0, 19);
    item = '{command: cmd, channel_code: code, time_seconds: secs};
    if (gap != 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid   <= 1'b1;
    in_chan.payload <= item;
    do @(posedge clk); while (!in_chan.ready);
    histogram_predict(item);
  endtask

  // the unused field of each command carries noise
  task automatic send_event(input logic [DATA_W-1:0] code);
    send_item(CMD_EVENT, code, $urandom);
  endtask

  task automatic send_tick(input logic [DATA_W-1:0] secs);
    send_item(CMD_TICK, $urandom, secs);
  endtask

  // mostly in-range events with a few hot channels, some rejects, rare ticks
  task automatic send_random_item();
    int unsigned       pick;
    logic [DATA_W-1:0] code;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      send_tick($urandom);
    end else if (pick < 18) begin
      do code = $urandom; while (code < CHANNELS);
      send_event(code);
    end else if (pick < 55) begin
      send_event($urandom_range(0, 3));
    end else begin
      send_event($urandom_range(0, CHANNELS - 1));
    end
  endtask

  // edges of the code range, empty and busy ticks, first-report flag
  task automatic test_directed();
    send_tick(32'h0000_0000);            // nothing counted yet
    send_event(0);
    send_event(CHANNELS - 1);
    send_event(CHANNELS - 1);
    send_event(CHANNELS);                // first code out of range
    send_event(32'hFFFF_FFFF);
    send_event(WIDE_CODE);
    send_event(32'h8000_0000);
    send_tick(32'hFFFF_FFFF);            // both ends reported for the first time
    send_event(0);
    send_event(5);
    send_tick(32'h0000_0000);            // channel 0 seen before, channel 5 not
    send_tick(32'h0000_0001);            // counters cleared by the previous tick
    send_event(1);
    send_tick(32'h5555_5555);            // single report carries last
    send_event(CHANNELS + 1);            // reject straight after a sweep
    send_event(32'h7FFF_FFFF);
  endtask

  // every channel busy, so one tick produces the largest burst of reports
  task automatic test_full_sweep();
    int unsigned offset;
    offset = $urandom_range(0, CHANNELS - 1);
    // odd stride visits every channel once, in scrambled order
    for (int i = 0; i < CHANNELS; i++)
      send_event((i * 37 + offset) % CHANNELS);
    repeat (4) send_event($urandom_range(0, CHANNELS - 1));
    send_tick($urandom);
  endtask

  // no gaps on either side: events land right behind ticks and rejects
  task automatic test_full_rate();
    tx_quiet = 1'b1;
    rx_quiet = 1'b1;
    repeat (50) send_random_item();
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
  endtask

  // long random run, idling switched on and off in stretches
  task automatic test_random_traffic();
    for (int i = 0; i < 170; i++) begin
      if (i % 30 == 0) begin
        tx_quiet = ($urandom_range(0, 3) == 0);
        rx_quiet = ($urandom_range(0, 3) == 0);
      end
      send_random_item();
    end
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
  endtask

  // result side: random stall before each transfer
  initial begin
    int unsigned stall;
    out_chan.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      stall = rx_quiet ? 0 : $urandom_range(0, 19);
      if (stall != 0) begin
        out_chan.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_chan.ready <= 1'b1;
      do @(posedge clk); while (!out_chan.valid);
    end
  end

  // compare each result transfer with the oldest expectation
  always @(posedge clk) begin : result_check
    out_item_t want;
    out_item_t got;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      got = out_chan.payload;
      if (expected_reports.size() == 0) begin
        $error("result with nothing expected: status %0d channel %0d",
               got.status, got.channel);
        mismatches++;
      end else begin
        want = expected_reports.pop_front();
        if (got.status !== want.status) begin
          $error("status mismatch: expected %0d, got %0d", want.status, got.status);
          mismatches++;
        end
        if (got.channel !== want.channel) begin
          $error("channel mismatch: expected %0d, got %0d", want.channel, got.channel);
          mismatches++;
        end
        if (got.count !== want.count) begin
          $error("count mismatch: expected %0d, got %0d", want.count, got.count);
          mismatches++;
        end
        if (got.timestamp !== want.timestamp) begin
          $error("timestamp mismatch: expected %0d, got %0d",
                 want.timestamp, got.timestamp);
          mismatches++;
        end
        if (got.first_report !== want.first_report) begin
          $error("first_report mismatch: expected %0d, got %0d",
                 want.first_report, got.first_report);
          mismatches++;
        end
        if (got.last !== want.last) begin
          $error("last mismatch: expected %0d, got %0d", want.last, got.last);
          mismatches++;
        end
      end
    end
  end

  // watchdog: too long without a transfer on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    for (int i = 0; i < CHANNELS; i++) begin
      chan_count[i] = '0;
      chan_seen[i]  = 1'b0;
    end
    rst_n           <= 1'b0;
    in_chan.valid   <= 1'b0;
    in_chan.payload <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_full_sweep();
    test_full_rate();
    test_random_traffic();

    in_chan.valid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    // room for a late sweep to show any stray report
    repeat (CHANNELS + 8) @(posedge clk);

    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
